// ----- design/ealt_pkg.sv -----
// ealt_pkg: shared types and constants of the address list tokenizer
// character codes, parse modes, result kinds, token forms and the result entry type
// no dependencies
package ealt_pkg;

   localparam int CharW        = 21;
   localparam int DefMaxDepth  = 15;
   localparam int FifoDepth    = 4;

   // character codes the tokenizer reacts to
   localparam logic [CharW-1:0] CH_COMMA     = 21'h00002C;
   localparam logic [CharW-1:0] CH_SEMI      = 21'h00003B;
   localparam logic [CharW-1:0] CH_QUOTE     = 21'h000022;
   localparam logic [CharW-1:0] CH_LPAREN    = 21'h000028;
   localparam logic [CharW-1:0] CH_RPAREN    = 21'h000029;
   localparam logic [CharW-1:0] CH_LANGLE    = 21'h00003C;
   localparam logic [CharW-1:0] CH_RANGLE    = 21'h00003E;
   localparam logic [CharW-1:0] CH_BACKSLASH = 21'h00005C;
   localparam logic [CharW-1:0] CH_SPACE     = 21'h000020;
   localparam logic [CharW-1:0] CH_NUL       = 21'h000000;

   // parse modes
   localparam logic [2:0] MODE_NORMAL      = 3'd0;
   localparam logic [2:0] MODE_QUOTE       = 3'd1;
   localparam logic [2:0] MODE_QUOTE_ESC   = 3'd2;
   localparam logic [2:0] MODE_COMMENT     = 3'd3;
   localparam logic [2:0] MODE_COMMENT_ESC = 3'd4;
   localparam logic [2:0] MODE_ANGLE       = 3'd5;

   // result kinds
   localparam logic [1:0] KIND_NAME    = 2'd0;
   localparam logic [1:0] KIND_ADDR    = 2'd1;
   localparam logic [1:0] KIND_COMMENT = 2'd2;
   localparam logic [1:0] KIND_END     = 2'd3;

   // token forms
   localparam logic [1:0] FORM_DISCARD  = 2'd0;
   localparam logic [1:0] FORM_NAME_ADR = 2'd1;
   localparam logic [1:0] FORM_NAME_IS  = 2'd2;

   // one result transaction
   typedef struct packed {
      logic [1:0]       kind;
      logic [CharW-1:0] char_val;
      logic [1:0]       form;
      logic             run_end;
   } result_type;

endpackage

// ----- design/email_address_list_tokenizer_unit.sv -----
// email_address_list_tokenizer_unit: top level of the address list tokenizer
// per-character parser feeding a four-entry result queue
// depends on ealt_pkg
//
// Usage
//   req channel: one character per transaction, tdata[20:0] holds the code
//   point, tlast marks the final character of a text (the open token is then
//   flushed and all parse state returns to its reset value).
//   rsp channel: one tagged result per transaction, tuser gives the kind
//   (name, address, comment character or token end), tdata the character and
//   the token form, tlast marks the last result caused by one character.
//   A character is parsed in the cycle it is accepted and its results (zero
//   to three) enter the result queue at once; the first appears on rsp in
//   the next cycle. While rsp_tready is high, a character that causes one
//   result or none is taken every cycle; one causing more results holds the
//   input off as the queue drains one result per cycle at its output port.
//   req_tready comes from the registered queue fill level only, so a stalled
//   receiver simply lets the queue fill and then holds the input off; no
//   result is lost or repeated.
//   Reset (synchronous, active high) empties the queue and puts the parser
//   in normal mode with an empty token.
module email_address_list_tokenizer_unit #(
   parameter int MAX_DEPTH = ealt_pkg::DefMaxDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [20:0] ch, [23:21] zero
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] out_char, [22:21] token_form, [23] zero
   output logic [1:0]  rsp_tuser,   // [1:0] res_kind
   output logic        rsp_tlast    // run_end
);
   import ealt_pkg::*;

   localparam int DepthW = $clog2(MAX_DEPTH + 1);
   localparam int PtrW   = $clog2(FifoDepth);
   localparam int CntW   = $clog2(FifoDepth + 1);

   // parser state
   logic [2:0]        mode_ff, mode_in;
   logic [DepthW-1:0] depth_ff, depth_in;
   logic              space_pend_ff, space_pend_in;
   logic              last_space_ff, last_space_in;
   logic              name_ne_ff, name_ne_in;
   logic              addr_ne_ff, addr_ne_in;

   // result queue
   result_type        fifo_ff [FifoDepth];
   logic [PtrW-1:0]   wptr_ff, wptr_in;
   logic [PtrW-1:0]   rptr_ff, rptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   logic              req_accept;
   logic              rsp_accept;
   logic [CharW-1:0]  ch;

   // candidate results of one character: pending space, main, comma end, text end
   logic [3:0]        cand_vld;
   result_type        cand [4];
   logic [1:0]        main_kind;
   logic              comma_end;
   logic              main_name;
   logic              name_after;
   logic              addr_after;
   logic [1:0]        end_form;
   logic [CntW-1:0]   push_n;
   logic [FifoDepth-1:0] wr_en;
   result_type        wr_data [FifoDepth];
   logic [PtrW-1:0]   slot;
   logic [PtrW-1:0]   pos;

   assign ch         = req_tdata[CharW-1:0];
   assign req_tready = (count_ff <= CntW'(1));
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_accept = rsp_tvalid && rsp_tready;

   // character classification and next parser state
   always_comb begin
      mode_in       = mode_ff;
      depth_in      = depth_ff;
      space_pend_in = space_pend_ff;
      last_space_in = last_space_ff;
      name_ne_in    = name_ne_ff;
      addr_ne_in    = addr_ne_ff;
      cand_vld      = '0;
      main_kind     = KIND_NAME;
      comma_end     = 1'b0;
      main_name     = 1'b0;
      case (mode_ff)
         MODE_QUOTE: begin
            if (ch == CH_QUOTE) begin
               mode_in = MODE_NORMAL;
            end else if (ch == CH_BACKSLASH) begin
               mode_in = MODE_QUOTE_ESC;
            end else begin
               main_name = 1'b1;
            end
         end
         MODE_QUOTE_ESC: begin
            main_name = 1'b1;
            mode_in   = MODE_QUOTE;
         end
         MODE_COMMENT: begin
            if (ch == CH_RPAREN) begin
               cand_vld[1] = (depth_ff > DepthW'(1));
               main_kind   = KIND_COMMENT;
               if (depth_ff != '0) begin
                  depth_in = depth_ff - DepthW'(1);
               end
               if (depth_ff <= DepthW'(1)) begin
                  mode_in = MODE_NORMAL;
               end
            end else if (ch == CH_LPAREN) begin
               cand_vld[1] = 1'b1;
               main_kind   = KIND_COMMENT;
               if (depth_ff < DepthW'(MAX_DEPTH)) begin
                  depth_in = depth_ff + DepthW'(1);
               end
            end else if (ch == CH_BACKSLASH) begin
               mode_in = MODE_COMMENT_ESC;
            end else begin
               cand_vld[1] = 1'b1;
               main_kind   = KIND_COMMENT;
            end
         end
         MODE_COMMENT_ESC: begin
            cand_vld[1] = 1'b1;
            main_kind   = KIND_COMMENT;
            mode_in     = MODE_COMMENT;
         end
         MODE_ANGLE: begin
            if (ch == CH_RANGLE) begin
               mode_in = MODE_NORMAL;
            end else begin
               cand_vld[1] = 1'b1;
               main_kind   = KIND_ADDR;
               addr_ne_in  = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_NORMAL;
            if (ch == CH_COMMA || ch == CH_SEMI) begin
               comma_end     = 1'b1;
               space_pend_in = 1'b0;
               last_space_in = 1'b0;
               name_ne_in    = 1'b0;
               addr_ne_in    = 1'b0;
            end else if (ch == CH_QUOTE) begin
               mode_in = MODE_QUOTE;
            end else if (ch == CH_LPAREN) begin
               mode_in  = MODE_COMMENT;
               depth_in = DepthW'(1);
            end else if (ch == CH_LANGLE) begin
               mode_in = MODE_ANGLE;
            end else if (ch == CH_SPACE) begin
               if (name_ne_ff && !last_space_ff) begin
                  space_pend_in = 1'b1;
               end
            end else begin
               main_name = 1'b1;
            end
         end
      endcase

      // name character with collapsed space in front
      if (main_name) begin
         cand_vld[0]   = space_pend_ff && (ch != CH_SPACE);
         cand_vld[1]   = 1'b1;
         main_kind     = KIND_NAME;
         space_pend_in = 1'b0;
         name_ne_in    = 1'b1;
         last_space_in = (ch == CH_SPACE);
      end
      name_after  = name_ne_in;
      addr_after  = addr_ne_in;
      cand_vld[2] = comma_end;
      cand_vld[3] = req_tlast;

      // end of text flushes and returns to reset state
      if (req_tlast) begin
         mode_in       = MODE_NORMAL;
         depth_in      = '0;
         space_pend_in = 1'b0;
         last_space_in = 1'b0;
         name_ne_in    = 1'b0;
         addr_ne_in    = 1'b0;
      end
   end

   // token forms and candidate payloads
   always_comb begin
      end_form = addr_after ? FORM_NAME_ADR : (name_after ? FORM_NAME_IS : FORM_DISCARD);
      cand[0]  = '{kind: KIND_NAME, char_val: CH_SPACE, form: FORM_DISCARD,
                   run_end: !(|cand_vld[3:1])};
      cand[1]  = '{kind: main_kind, char_val: ch, form: FORM_DISCARD,
                   run_end: !(|cand_vld[3:2])};
      cand[2]  = '{kind: KIND_END, char_val: CH_NUL,
                   form: addr_ne_ff ? FORM_NAME_ADR :
                         (name_ne_ff ? FORM_NAME_IS : FORM_DISCARD),
                   run_end: !cand_vld[3]};
      cand[3]  = '{kind: KIND_END, char_val: CH_NUL,
                   form: comma_end ? FORM_DISCARD : end_form, run_end: 1'b1};
   end

   // compact the candidates into consecutive queue slots
   always_comb begin
      wr_en  = '0;
      slot   = '0;
      pos    = '0;
      push_n = '0;
      for (int i = 0; i < FifoDepth; i++) begin
         wr_data[i] = cand[0];
      end
      for (int k = 0; k < 4; k++) begin
         if (cand_vld[k]) begin
            pos          = wptr_ff + slot;
            wr_en[pos]   = req_accept;
            wr_data[pos] = cand[k];
            slot         = slot + PtrW'(1);
            push_n       = push_n + CntW'(1);
         end
      end
      if (!req_accept) begin
         push_n = '0;
      end
      wptr_in  = wptr_ff + push_n[PtrW-1:0];
      rptr_in  = rptr_ff + PtrW'(rsp_accept);
      count_in = count_ff + push_n - CntW'(rsp_accept);
   end

   // queue storage
   always_ff @(posedge clock) begin
      for (int i = 0; i < FifoDepth; i++) begin
         if (wr_en[i]) begin
            fifo_ff[i] <= wr_data[i];
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_NORMAL;
         depth_ff      <= '0;
         space_pend_ff <= 1'b0;
         last_space_ff <= 1'b0;
         name_ne_ff    <= 1'b0;
         addr_ne_ff    <= 1'b0;
         wptr_ff       <= '0;
         rptr_ff       <= '0;
         count_ff      <= '0;
      end else begin
         if (req_accept) begin
            mode_ff       <= mode_in;
            depth_ff      <= depth_in;
            space_pend_ff <= space_pend_in;
            last_space_ff <= last_space_in;
            name_ne_ff    <= name_ne_in;
            addr_ne_ff    <= addr_ne_in;
         end
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // output port from the queue head
   assign rsp_tdata = {1'b0, fifo_ff[rptr_ff].form, fifo_ff[rptr_ff].char_val};
   assign rsp_tuser = fifo_ff[rptr_ff].kind;
   assign rsp_tlast = fifo_ff[rptr_ff].run_end;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(FifoDepth))
      else $error("result queue overfilled");

   a_comment_depth: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_COMMENT || mode_ff == MODE_COMMENT_ESC) |-> depth_ff != '0)
      else $error("comment mode with zero depth");

   a_space_pending: assert property (@(posedge clock) disable iff (reset)
      space_pend_ff |-> (name_ne_ff && !last_space_ff))
      else $error("space pending without a name character before it");

   a_text_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> (mode_ff == MODE_NORMAL && depth_ff == '0
                                     && !name_ne_ff && !addr_ne_ff))
      else $error("parser state not cleared after end of text");

endmodule

// ----- tb/sv/tb_email_address_list_tokenizer_unit.sv -----
// tb_email_address_list_tokenizer_unit: self-checking bench for the address list tokenizer
// directed character table with typed or predicted results, then random address lists checked against a local predictor
// depends on ealt_pkg and email_address_list_tokenizer_unit
module tb_email_address_list_tokenizer_unit;
   import ealt_pkg::*;

   localparam int NestLimit    = DefMaxDepth;
   localparam int RandomItems  = 240;
   localparam int MaxReports   = 10;
   localparam int USE_PREDICTOR = -1;

   typedef struct {
      logic [CharW-1:0] ch;
      logic             eot;
   } text_char_type;

   typedef struct {
      logic [CharW-1:0] ch;
      logic             eot;
      int               typed_n;   // USE_PREDICTOR, or number of typed results (0 or 1)
      result_type       typed_r;
   } table_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   // predictor state
   logic [2:0]  mode;
   int          nest;
   logic        gap_space;
   logic        name_ends_space;
   logic        have_name;
   logic        have_addr;
   int          deepest_nest;

   result_type    step_results[$];
   result_type    expected_q[$];
   table_row_type char_table[$];
   text_char_type text_q[$];

   int chars_sent;
   int random_sent;
   int results_seen;
   int token_ends_seen;
   int mismatches;
   int burst_left;
   int stall_mode;
   int cycle_count;

   email_address_list_tokenizer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // clock, period 20
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void emit_result(logic [1:0] kind, logic [CharW-1:0] c, logic [1:0] form);
      result_type r;
      r.kind     = kind;
      r.char_val = c;
      r.form     = form;
      r.run_end  = 1'b0;
      step_results.push_back(r);
   endfunction

   // name character, with the pending collapsed space placed in front of it
   function automatic void name_append(logic [CharW-1:0] c);
      if (gap_space && c != CH_SPACE) begin
         emit_result(KIND_NAME, CH_SPACE, FORM_DISCARD);
      end
      gap_space       = 1'b0;
      emit_result(KIND_NAME, c, FORM_DISCARD);
      have_name       = 1'b1;
      name_ends_space = (c == CH_SPACE);
   endfunction

   function automatic void close_token();
      logic [1:0] form;
      form = have_addr ? FORM_NAME_ADR : (have_name ? FORM_NAME_IS : FORM_DISCARD);
      emit_result(KIND_END, CH_NUL, form);
      gap_space       = 1'b0;
      name_ends_space = 1'b0;
      have_name       = 1'b0;
      have_addr       = 1'b0;
   endfunction

   function automatic void clear_parser();
      mode            = MODE_NORMAL;
      nest            = 0;
      gap_space       = 1'b0;
      name_ends_space = 1'b0;
      have_name       = 1'b0;
      have_addr       = 1'b0;
   endfunction

   // results of one character, left in step_results
   function automatic void tokenize_char(logic [CharW-1:0] c, logic eot);
      result_type r;
      step_results.delete();
      case (mode)
         MODE_QUOTE: begin
            if (c == CH_QUOTE) mode = MODE_NORMAL;
            else if (c == CH_BACKSLASH) mode = MODE_QUOTE_ESC;
            else name_append(c);
         end
         MODE_QUOTE_ESC: begin
            name_append(c);
            mode = MODE_QUOTE;
         end
         MODE_COMMENT: begin
            if (c == CH_RPAREN) begin
               // outermost closing parenthesis is dropped
               if (nest > 1) emit_result(KIND_COMMENT, c, FORM_DISCARD);
               if (nest > 0) nest = nest - 1;
               if (nest == 0) mode = MODE_NORMAL;
            end else if (c == CH_LPAREN) begin
               emit_result(KIND_COMMENT, c, FORM_DISCARD);
               if (nest < NestLimit) nest = nest + 1;
            end else if (c == CH_BACKSLASH) begin
               mode = MODE_COMMENT_ESC;
            end else begin
               emit_result(KIND_COMMENT, c, FORM_DISCARD);
            end
         end
         MODE_COMMENT_ESC: begin
            emit_result(KIND_COMMENT, c, FORM_DISCARD);
            mode = MODE_COMMENT;
         end
         MODE_ANGLE: begin
            if (c == CH_RANGLE) begin
               mode = MODE_NORMAL;
            end else begin
               emit_result(KIND_ADDR, c, FORM_DISCARD);
               have_addr = 1'b1;
            end
         end
         default: begin
            mode = MODE_NORMAL;
            if (c == CH_COMMA || c == CH_SEMI) begin
               close_token();
            end else if (c == CH_QUOTE) begin
               mode = MODE_QUOTE;
            end else if (c == CH_LPAREN) begin
               mode = MODE_COMMENT;
               nest = 1;
            end else if (c == CH_LANGLE) begin
               mode = MODE_ANGLE;
            end else if (c == CH_SPACE) begin
               if (have_name && !name_ends_space) gap_space = 1'b1;
            end else begin
               name_append(c);
            end
         end
      endcase
      if (nest > deepest_nest) deepest_nest = nest;
      if (eot) begin
         close_token();
         clear_parser();
      end
      if (step_results.size() > 0) begin
         r = step_results.pop_back();
         r.run_end = 1'b1;
         step_results.push_back(r);
      end
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic void add_row(logic [CharW-1:0] c, logic eot, int typed_n,
                                   logic [1:0] kind, logic [CharW-1:0] rc, logic [1:0] form);
      table_row_type row;
      row.ch               = c;
      row.eot              = eot;
      row.typed_n          = typed_n;
      row.typed_r.kind     = kind;
      row.typed_r.char_val = rc;
      row.typed_r.form     = form;
      row.typed_r.run_end  = 1'b1;
      char_table.push_back(row);
   endfunction

   function automatic void put_char(logic [CharW-1:0] c);
      text_char_type t;
      t.ch  = c;
      t.eot = 1'b0;
      text_q.push_back(t);
   endfunction

   function automatic void mark_end_of_text();
      text_char_type t;
      t = text_q.pop_back();
      t.eot = 1'b1;
      text_q.push_back(t);
   endfunction

   function automatic logic [CharW-1:0] pick_text_char();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7) return CharW'($urandom_range(8'h61, 8'h7A));
      else if (sel == 7) return CharW'($urandom_range(8'h2E, 8'h40));
      else return CharW'($urandom_range(0, 21'h1FFFFF));
   endfunction

   // one list entry: display name words, quoted parts, comments, address, separator or end of text
   task automatic build_entry();
      int words;
      int depth;
      int sel;
      words = $urandom_range(0, 3);
      repeat ($urandom_range(0, 2)) put_char(CH_SPACE);
      for (int k = 0; k < words; k++) begin
         sel = $urandom_range(0, 5);
         if (sel == 0) begin
            put_char(CH_QUOTE);
            repeat ($urandom_range(0, 4)) begin
               case ($urandom_range(0, 3))
                  0: put_char(CH_SPACE);
                  1: begin
                     put_char(CH_BACKSLASH);
                     put_char(($urandom_range(0, 1) == 0) ? CH_QUOTE : pick_text_char());
                  end
                  default: put_char(pick_text_char());
               endcase
            end
            put_char(CH_QUOTE);
         end else if (sel == 1) begin
            // now and then nest to the saturation limit or beyond it
            depth = ($urandom_range(0, 7) == 0) ? $urandom_range(NestLimit, NestLimit + 3)
                                                : $urandom_range(1, 3);
            repeat (depth) put_char(CH_LPAREN);
            repeat ($urandom_range(0, 3)) begin
               if ($urandom_range(0, 3) == 0) begin
                  put_char(CH_BACKSLASH);
                  put_char(($urandom_range(0, 1) == 0) ? CH_RPAREN : pick_text_char());
               end else begin
                  put_char(pick_text_char());
               end
            end
            repeat (depth) put_char(CH_RPAREN);
         end else begin
            repeat ($urandom_range(1, 4)) put_char(pick_text_char());
         end
         repeat ($urandom_range(0, 2)) put_char(CH_SPACE);
      end
      if ($urandom_range(0, 2) != 0) begin
         put_char(CH_LANGLE);
         repeat ($urandom_range(0, 5)) put_char(pick_text_char());
         put_char(CH_RANGLE);
      end
      if ($urandom_range(0, 5) == 0) put_char(CH_SPACE);
      // entry end: separator, end of text, or a text cut off inside a construct
      sel = $urandom_range(0, 11);
      if (sel == 0) begin
         case ($urandom_range(0, 4))
            0: put_char(CH_QUOTE);
            1: put_char(CH_LPAREN);
            2: put_char(CH_LANGLE);
            3: begin
               put_char(CH_QUOTE);
               put_char(CH_BACKSLASH);
            end
            default: begin
               put_char(CH_LPAREN);
               put_char(CH_BACKSLASH);
            end
         endcase
         mark_end_of_text();
      end else if (sel == 1 && text_q.size() > 0) begin
         mark_end_of_text();
      end else begin
         put_char(($urandom_range(0, 1) == 0) ? CH_COMMA : CH_SEMI);
         if ($urandom_range(0, 4) == 0) mark_end_of_text();
      end
   endtask

   // drive one character and wait for its acceptance
   task automatic send_char(logic [CharW-1:0] c, logic eot, int typed_n, result_type typed_r);
      req_tdata  <= {3'b000, c};
      req_tlast  <= eot;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tokenize_char(c, eot);
      if (typed_n == USE_PREDICTOR) begin
         foreach (step_results[i]) expected_q.push_back(step_results[i]);
      end else if (typed_n == 1) begin
         expected_q.push_back(typed_r);
      end
      chars_sent++;
   endtask

   // bursts of random length with random gaps between them
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // hold the sender until every expected result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- result checking

   task automatic log_mismatch(string what, result_type exp_r, result_type got_r);
      mismatches++;
      if (mismatches <= MaxReports) begin
         $display("mismatch (%s) at %0t: expected kind %0d char %h form %0d last %0b,",
                  what, $realtime, exp_r.kind, exp_r.char_val, exp_r.form, exp_r.run_end);
         $display("   got kind %0d char %h form %0d last %0b",
                  got_r.kind, got_r.char_val, got_r.form, got_r.run_end);
      end
   endtask

   always @(posedge clock) begin
      result_type got_r;
      result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_r.kind     = rsp_tuser;
         got_r.char_val = rsp_tdata[CharW-1:0];
         got_r.form     = rsp_tdata[22:21];
         got_r.run_end  = rsp_tlast;
         results_seen++;
         if (rsp_tuser == KIND_END) token_ends_seen++;
         if (expected_q.size() == 0) begin
            exp_r = '0;
            log_mismatch("no result expected", exp_r, got_r);
         end else begin
            exp_r = expected_q.pop_front();
            if (got_r !== exp_r || rsp_tdata[23] !== 1'b0) log_mismatch("field", exp_r, got_r);
         end
      end

      // receiver stall pattern, switched between four random modes
      cycle_count++;
      if (cycle_count % 48 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 1) == 0);
         2:       rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= ((cycle_count % 7) < 4);
      endcase
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      rsp_tready   = 1'b0;
      chars_sent   = 0;
      random_sent  = 0;
      results_seen = 0;
      token_ends_seen = 0;
      mismatches   = 0;
      burst_left   = 0;
      stall_mode   = 0;
      cycle_count  = 0;
      deepest_nest = 0;
      clear_parser();

      // directed table: typed results where they are plain to see
      add_row(CH_COMMA,     1'b0, 1, KIND_END,     CH_NUL,       FORM_DISCARD);
      add_row(21'h000041,   1'b0, 1, KIND_NAME,    21'h000041,   FORM_DISCARD);
      add_row(CH_SPACE,     1'b0, 0, KIND_NAME,    CH_NUL,       FORM_DISCARD);
      add_row(CH_SPACE,     1'b0, 0, KIND_NAME,    CH_NUL,       FORM_DISCARD);
      add_row(21'h000062,   1'b0, USE_PREDICTOR, KIND_NAME, CH_NUL, FORM_DISCARD);
      add_row(CH_LANGLE,    1'b0, 0, KIND_NAME,    CH_NUL,       FORM_DISCARD);
      add_row(21'h1FFFFF,   1'b0, 1, KIND_ADDR,    21'h1FFFFF,   FORM_DISCARD);
      add_row(CH_RANGLE,    1'b0, 0, KIND_NAME,    CH_NUL,       FORM_DISCARD);
      add_row(CH_SEMI,      1'b0, 1, KIND_END,     CH_NUL,       FORM_NAME_ADR);
      add_row(CH_QUOTE,     1'b0, 0, KIND_NAME,    CH_NUL,       FORM_DISCARD);
      add_row(CH_SPACE,     1'b0, 1, KIND_NAME,    CH_SPACE,     FORM_DISCARD);
      add_row(CH_BACKSLASH, 1'b0, 0, KIND_NAME,    CH_NUL,       FORM_DISCARD);
      add_row(CH_QUOTE,     1'b0, 1, KIND_NAME,    CH_QUOTE,     FORM_DISCARD);
      add_row(CH_QUOTE,     1'b0, 0, KIND_NAME,    CH_NUL,       FORM_DISCARD);
      // pending space swallowed by a quoted space
      add_row(CH_SPACE,     1'b0, USE_PREDICTOR, KIND_NAME, CH_NUL, FORM_DISCARD);
      add_row(CH_QUOTE,     1'b0, USE_PREDICTOR, KIND_NAME, CH_NUL, FORM_DISCARD);
      add_row(CH_SPACE,     1'b0, USE_PREDICTOR, KIND_NAME, CH_NUL, FORM_DISCARD);
      add_row(CH_QUOTE,     1'b0, USE_PREDICTOR, KIND_NAME, CH_NUL, FORM_DISCARD);
      // nested comment with an escaped parenthesis
      add_row(CH_LPAREN,    1'b0, USE_PREDICTOR, KIND_NAME, CH_NUL, FORM_DISCARD);
      add_row(CH_LPAREN,    1'b0, 1, KIND_COMMENT, CH_LPAREN,    FORM_DISCARD);
      add_row(CH_BACKSLASH, 1'b0, 0, KIND_NAME,    CH_NUL,       FORM_DISCARD);
      add_row(CH_RPAREN,    1'b0, 1, KIND_COMMENT, CH_RPAREN,    FORM_DISCARD);
      add_row(CH_RPAREN,    1'b0, USE_PREDICTOR, KIND_NAME, CH_NUL, FORM_DISCARD);
      add_row(CH_RPAREN,    1'b0, USE_PREDICTOR, KIND_NAME, CH_NUL, FORM_DISCARD);
      // pending space, then NUL closing the text: three results
      add_row(21'h00007A,   1'b0, USE_PREDICTOR, KIND_NAME, CH_NUL, FORM_DISCARD);
      add_row(CH_SPACE,     1'b0, USE_PREDICTOR, KIND_NAME, CH_NUL, FORM_DISCARD);
      add_row(CH_NUL,       1'b1, USE_PREDICTOR, KIND_NAME, CH_NUL, FORM_DISCARD);
      // quote left open at end of text
      add_row(CH_QUOTE,     1'b1, 1, KIND_END,     CH_NUL,       FORM_DISCARD);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (char_table[i]) begin
         send_char(char_table[i].ch, char_table[i].eot, char_table[i].typed_n,
                   char_table[i].typed_r);
         pace_sender();
      end
      drain_results();

      // random address lists
      while (random_sent < RandomItems) begin
         build_entry();
         while (text_q.size() > 0) begin
            text_char_type t;
            t = text_q.pop_front();
            send_char(t.ch, t.eot, USE_PREDICTOR, '0);
            random_sent++;
            if (random_sent == RandomItems / 2) drain_results();
            else pace_sender();
         end
      end

      drain_results();
      repeat (20) @(posedge clock);

      $display("sent %0d characters, checked %0d results including %0d token ends",
               chars_sent, results_seen, token_ends_seen);
      $display("comment nesting reached %0d (limit %0d), %0d mismatches",
               deepest_nest, NestLimit, mismatches);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
